@@ rtl/nsp_pkg.sv @@
// Shared types and constants for the sign-pack quantizer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package nsp_pkg;

  localparam int unsigned ElemW      = 32;
  localparam int unsigned ScaleW     = 32;
  localparam int unsigned ScaleShift = 24;
  localparam int unsigned ProdW      = 64;
  localparam int unsigned MagW       = 31;
  localparam int unsigned SumW       = 48;
  localparam int unsigned WordBits   = 64;
  localparam int unsigned PosW       = $clog2(WordBits);
  localparam int unsigned WordIdxW   = 6;

  localparam logic [ScaleW-1:0] ScaleReset = 32'h0100_0000;
  localparam logic [MagW-1:0]   MagMax     = {MagW{1'b1}};
  localparam logic [PosW-1:0]   LastPos    = PosW'(WordBits - 1);

  typedef struct packed {
    logic signed [ElemW-1:0] element_value;
    logic                    final_element;
  } in_item_t;

  typedef struct packed {
    logic signed [ElemW-1:0]    scaled_value;
    logic [WordBits-1:0]        sign_word;
    logic                       word_ready;
    logic [WordIdxW-1:0]        word_index;
    logic signed [SumW-1:0]     running_sum;
    logic [MagW-1:0]            largest_magnitude;
    logic                       vector_done;
  } out_item_t;

  // Scaled element handed from the multiply stages to the accumulate stage.
  typedef struct packed {
    logic signed [ElemW-1:0] value;
    logic [MagW-1:0]         mag;
    logic                    final_element;
  } scaled_t;

endpackage

`default_nettype wire

@@ rtl/nsp_scale.sv @@
// Multiply and round/saturate stages of the sign-pack quantizer.
// Depends on nsp_pkg for the item and scaled-value types.
`default_nettype none

module nsp_scale
  import nsp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ScaleW-1:0] scale_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_item_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output scaled_t                out_data_o
);

  // Product stage
  logic             prod_valid_q;
  logic [ProdW-1:0] prod_q;
  logic             prod_neg_q;
  logic             prod_final_q;
  logic             prod_ld;

  // Scaled stage
  logic             scl_valid_q;
  scaled_t          scl_q;
  logic             scl_ld;

  logic [ElemW-1:0] mag_in;
  logic [ProdW-1:0] rounded;
  logic [ProdW-ScaleShift-1:0] quot;
  logic [MagW-1:0]  mag_sat;

  assign scl_ld     = !scl_valid_q || out_ready_i;
  assign prod_ld    = !prod_valid_q || scl_ld;
  assign in_ready_o = prod_ld;

  // Two's complement magnitude; the most negative input maps to 2^31.
  assign mag_in = in_data_i.element_value[ElemW-1] ?
                  (~in_data_i.element_value + 1'b1) : in_data_i.element_value;

  // Negative values round the magnitude up so the signed result floors.
  assign rounded = prod_q + (prod_neg_q ? ProdW'((64'd1 << ScaleShift) - 64'd1) : '0);
  assign quot    = rounded[ProdW-1:ScaleShift];
  assign mag_sat = (quot > (ProdW-ScaleShift)'(MagMax)) ? MagMax : quot[MagW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      scl_valid_q  <= 1'b0;
    end else begin
      if (prod_ld) begin
        prod_valid_q <= in_valid_i;
      end
      if (scl_ld) begin
        scl_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_ld && in_valid_i) begin
      prod_q       <= ProdW'(mag_in) * ProdW'(scale_i);
      prod_neg_q   <= in_data_i.element_value[ElemW-1];
      prod_final_q <= in_data_i.final_element;
    end
    if (scl_ld && prod_valid_q) begin
      scl_q.mag           <= mag_sat;
      scl_q.value         <= prod_neg_q ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});
      scl_q.final_element <= prod_final_q;
    end
  end

  assign out_valid_o = scl_valid_q;
  assign out_data_o  = scl_q;

endmodule

`default_nettype wire

@@ rtl/nsp_accum.sv @@
// Accumulate stage: running sum, running maximum and sign-bit packing.
// Holds the per-vector state and the result register; depends on nsp_pkg.
`default_nettype none

module nsp_accum
  import nsp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire scaled_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output out_item_t    out_data_o
);

  logic signed [SumW-1:0] sum_q;
  logic [MagW-1:0]        max_q;
  logic [WordBits-1:0]    bits_q;
  logic [PosW-1:0]        pos_q;
  logic [WordIdxW-1:0]    word_cnt_q;

  logic signed [SumW-1:0] sum_d;
  logic [MagW-1:0]        max_d;
  logic [WordBits-1:0]    bits_d;
  logic [SumW:0]          sum_wide;
  logic                   full;
  logic                   release_word;
  logic                   ld;
  logic                   take;

  logic                   res_valid_q;
  out_item_t              res_q;

  assign ld         = !res_valid_q || out_ready_i;
  assign take       = ld && in_valid_i;
  assign in_ready_o = ld;

  always_comb begin
    sum_wide = {sum_q[SumW-1], sum_q} + (SumW+1)'(in_data_i.value);
    // Saturate when the two top bits disagree.
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_d = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_d = sum_wide[SumW-1:0];
    end
    max_d        = (in_data_i.mag > max_q) ? in_data_i.mag : max_q;
    bits_d       = bits_q | (in_data_i.value[ElemW-1] ? '0 : (WordBits'(1) << pos_q));
    full         = (pos_q == LastPos);
    release_word = full || in_data_i.final_element;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      sum_q       <= '0;
      max_q       <= '0;
      bits_q      <= '0;
      pos_q       <= '0;
      word_cnt_q  <= '0;
    end else begin
      if (ld) begin
        res_valid_q <= in_valid_i;
      end
      if (take) begin
        if (release_word) begin
          bits_q <= '0;
          pos_q  <= '0;
        end else begin
          bits_q <= bits_d;
          pos_q  <= pos_q + 1'b1;
        end
        if (in_data_i.final_element) begin
          sum_q      <= '0;
          max_q      <= '0;
          word_cnt_q <= '0;
        end else begin
          sum_q      <= sum_d;
          max_q      <= max_d;
          word_cnt_q <= release_word ? word_cnt_q + 1'b1 : word_cnt_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q.scaled_value      <= in_data_i.value;
      res_q.sign_word         <= bits_d;
      res_q.word_ready        <= release_word;
      res_q.word_index        <= word_cnt_q;
      res_q.running_sum       <= sum_d;
      res_q.largest_magnitude <= max_d;
      res_q.vector_done       <= in_data_i.final_element;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

@@ rtl/normalize_sign_pack_core.sv @@
// Sign-pack quantizer: scales Q16.16 elements by a Q8.24 register, tracks the
// running sum and largest magnitude per vector, and packs one sign bit per
// element into 64-bit words. Takes one element per clock cycle when the
// output is taken every cycle; each element passes the input, product,
// rounded value and result registers in that order. The accumulate stage
// closes a loop through its sum, maximum and sign-word registers.
// Write scale_factor only while no element is in flight.
// Depends on nsp_pkg, nsp_scale and nsp_accum.
`default_nettype none

module normalize_sign_pack_core
  import nsp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [ScaleW-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_item_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_item_t              out_data_o
);

  logic [ScaleW-1:0] scale_q;
  logic              inp_valid_q;
  in_item_t          inp_q;
  logic              inp_ld;
  logic              scl_in_ready;
  logic              scl_valid;
  scaled_t           scl_data;
  logic              acc_ready;
  logic [ElemW-1:0]  out_mag;

  assign inp_ld     = !inp_valid_q || scl_in_ready;
  assign in_ready_o = inp_ld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= ScaleReset;
      inp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      if (inp_ld) begin
        inp_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (inp_ld && in_valid_i) begin
      inp_q <= in_data_i;
    end
  end

  nsp_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scale_i     (scale_q),
    .in_valid_i  (inp_valid_q),
    .in_ready_o  (scl_in_ready),
    .in_data_i   (inp_q),
    .out_valid_o (scl_valid),
    .out_ready_i (acc_ready),
    .out_data_o  (scl_data)
  );

  nsp_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (scl_valid),
    .in_ready_o  (acc_ready),
    .in_data_i   (scl_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  assign out_mag = out_data_o.scaled_value[ElemW-1] ?
                   (~out_data_o.scaled_value + 1'b1) : out_data_o.scaled_value;

  // The last element of a vector always releases its sign word.
  a_done_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.vector_done || out_data_o.word_ready))
    else $error("final element did not release the sign word");

  // The running maximum covers the element reported with it.
  a_max_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_mag <= ElemW'(out_data_o.largest_magnitude)))
    else $error("largest magnitude below current scaled value");

  // The top sign bit can only be set by the element that fills the word.
  a_partial_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.word_ready) |-> !out_data_o.sign_word[WordBits-1])
    else $error("partial sign word has its top bit set");

endmodule

`default_nettype wire
